@@ rtl/core/bmwm_pkg.sv @@
// ----------------------------------------------------------------------------
// bmwm_pkg
// shared widths, codes and mask levels for the box mean white mask core
// ----------------------------------------------------------------------------
package bmwm_pkg;

  // line geometry
  localparam int MAX_LINE_WIDTH = 1024;
  localparam int MIN_LINE_WIDTH = 3;
  localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
  localparam int LINE_W_W       = 11;
  localparam int ROW_W          = 2;

  // pixel and window arithmetic
  localparam int CHAN_W   = 8;
  localparam int NUM_CHAN = 3;
  localparam int PIX_W    = CHAN_W * NUM_CHAN;
  localparam int LINE_W   = 2 * PIX_W;
  localparam int COLSUM_W = 10;
  localparam int SUM_W    = 12;
  localparam int BOUND_W  = 13;
  localparam int BAND_W   = 8;

  localparam logic [CHAN_W-1:0] WHITE_LEVEL = 8'd255;

  // mask levels
  localparam int MASK_W = 8;
  localparam logic [MASK_W-1:0] MASK_WHITE  = 8'd255;
  localparam logic [MASK_W-1:0] MASK_OTHER  = 8'd127;
  localparam logic [MASK_W-1:0] MASK_BORDER = 8'd0;

  // configuration registers
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = LINE_W_W;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_BAND = 1'd1;

  localparam logic [LINE_W_W-1:0] LINE_WIDTH_RST = 11'd640;
  localparam logic [BAND_W-1:0]   WHITE_BAND_RST = 8'd51;

endpackage

@@ rtl/core/box_mean_white_mask_core.sv @@
// ----------------------------------------------------------------------------
// box_mean_white_mask_core
// 3x3 box mean over a bgr raster stream, flags near-white pixels
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid / s_tready  tdata: blue, green, red   tuser: frame_start
//  m_*       out  m_tvalid / m_tready  tdata: mask_value         tuser: mask_valid
//  cfg_*     in   cfg_we               cfg_index, cfg_data (line_width, white_band)
//
//  one beat per cycle in and out while m_tready is high; a pixel's result goes
//  to the output register through the window stage (line ram read on the input
//  edge, then window and compare into the result register as the stage advances)
//  rst is synchronous; afterwards the line ram is swept to zero, one entry per
//  cycle, over all 1024 entries while s_tready stays low (config writes still taken)
//  a stall on m_tready holds the result register and then the window stage;
//  the input keeps taking beats as long as the window stage can move on
//
module box_mean_white_mask_core (
  input  logic                                clk,
  input  logic                                rst,
  // pixel input
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [bmwm_pkg::PIX_W-1:0]          s_tdata,   // blue, green, red
  input  logic [0:0]                          s_tuser,   // frame_start
  // mask output
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [bmwm_pkg::MASK_W-1:0]         m_tdata,   // mask_value
  output logic [0:0]                          m_tuser,   // mask_valid
  // configuration writes
  input  logic                                cfg_we,
  input  logic [bmwm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bmwm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import bmwm_pkg::*;

  // configuration registers
  logic [LINE_W_W-1:0] line_width;
  logic [BAND_W-1:0]   white_band;

  // line ram clearing sweep
  logic             clearing;
  logic [COL_W-1:0] clr_addr;

  // raster position
  logic [COL_W-1:0]    column_pos;
  logic [ROW_W-1:0]    row_pos;
  logic [COL_W-1:0]    col_cur;
  logic [ROW_W-1:0]    row_cur;
  logic [LINE_W_W-1:0] col_inc;
  logic [LINE_W_W-1:0] eff_width;
  logic                row_wrap;

  logic accept;

  // window stage
  logic              s1_valid;
  logic              s1_advance;
  logic [PIX_W-1:0]  s1_px;
  logic [COL_W-1:0]  s1_col;
  logic              s1_pos_valid;
  logic              s1_interior;
  logic              fwd;
  logic [LINE_W-1:0] fwd_data;

  // line ram: low half is the row above, high half two rows above
  logic [LINE_W-1:0] ram_rd_data;
  logic [LINE_W-1:0] line_rd;
  logic [LINE_W-1:0] line_wr;
  logic              ram_we;
  logic [COL_W-1:0]  ram_wr_addr;
  logic [LINE_W-1:0] ram_wr_data;
  logic [PIX_W-1:0]  above1;
  logic [PIX_W-1:0]  above2;

  // running column sums of the two older window columns
  logic [COLSUM_W-1:0] cs1 [NUM_CHAN];
  logic [COLSUM_W-1:0] cs2 [NUM_CHAN];
  logic [COLSUM_W-1:0] new_cs [NUM_CHAN];
  logic [SUM_W-1:0]    win_sum [NUM_CHAN];

  logic [CHAN_W-1:0]  band_lo;
  logic [CHAN_W:0]    band_hi;
  logic [BOUND_W-1:0] bound_lo;
  logic [BOUND_W-1:0] bound_hi;
  logic               white;
  logic [MASK_W-1:0]  mask;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RST;
      white_band <= WHITE_BAND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LINE_WIDTH: line_width <= cfg_data[LINE_W_W-1:0];
        CFG_WHITE_BAND: white_band <= cfg_data[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the row length into the supported range
  always_comb begin
    if (line_width < LINE_W_W'(MIN_LINE_WIDTH)) begin
      eff_width = LINE_W_W'(MIN_LINE_WIDTH);
    end else if (line_width > LINE_W_W'(MAX_LINE_WIDTH)) begin
      eff_width = LINE_W_W'(MAX_LINE_WIDTH);
    end else begin
      eff_width = line_width;
    end
  end

  // ---------------------------------------------------------------------------
  // clearing sweep after reset
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + COL_W'(1);
      if (clr_addr == COL_W'(MAX_LINE_WIDTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------------
  assign s1_advance = s1_valid && (!m_tvalid || m_tready);
  assign s_tready   = !clearing && (!s1_valid || s1_advance);
  assign accept     = s_tvalid && s_tready;

  // ---------------------------------------------------------------------------
  // raster position, frame_start restarts at the top left before placing
  // ---------------------------------------------------------------------------
  assign col_cur  = s_tuser[0] ? '0 : column_pos;
  assign row_cur  = s_tuser[0] ? '0 : row_pos;
  assign col_inc  = LINE_W_W'(col_cur) + LINE_W_W'(1);
  assign row_wrap = col_inc >= eff_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos    <= '0;
    end else if (accept) begin
      if (row_wrap) begin
        column_pos <= '0;
        // row count saturates at two, enough to know the window is full
        if (row_cur < ROW_W'(2)) begin
          row_pos <= row_cur + ROW_W'(1);
        end else begin
          row_pos <= row_cur;
        end
      end else begin
        column_pos <= col_inc[COL_W-1:0];
        row_pos    <= row_cur;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // line ram: read at accept, written back as the pixel leaves the window stage
  // ---------------------------------------------------------------------------
  assign ram_we      = clearing || s1_advance;
  assign ram_wr_addr = clearing ? clr_addr : s1_col;
  assign ram_wr_data = clearing ? '0 : line_wr;

  bmwm_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_LINE_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (accept),
    .rd_addr (col_cur),
    .rd_data (ram_rd_data)
  );

  // ---------------------------------------------------------------------------
  // window stage registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px        <= s_tdata;
      s1_col       <= col_cur;
      s1_pos_valid <= (row_cur >= ROW_W'(1)) && (col_cur >= COL_W'(1));
      s1_interior  <= (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
      // the ram read misses a write to the same entry on the same edge,
      // so keep that written line aside and use it instead
      fwd          <= s1_advance && (s1_col == col_cur);
      fwd_data     <= line_wr;
    end
  end

  assign line_rd = fwd ? fwd_data : ram_rd_data;
  assign above1  = line_rd[PIX_W-1:0];
  assign above2  = line_rd[LINE_W-1:PIX_W];
  // shift the line: the row above moves to two rows above, this pixel enters
  assign line_wr = {above1, s1_px};

  // ---------------------------------------------------------------------------
  // window sums, one channel per lane
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      new_cs[k]  = COLSUM_W'(above2[k*CHAN_W +: CHAN_W])
                 + COLSUM_W'(above1[k*CHAN_W +: CHAN_W])
                 + COLSUM_W'(s1_px[k*CHAN_W +: CHAN_W]);
      win_sum[k] = SUM_W'(cs1[k]) + SUM_W'(cs2[k]) + SUM_W'(new_cs[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CHAN; k++) begin
        cs1[k] <= '0;
        cs2[k] <= '0;
      end
    end else if (s1_advance) begin
      for (int k = 0; k < NUM_CHAN; k++) begin
        cs1[k] <= cs2[k];
        cs2[k] <= new_cs[k];
      end
    end
  end

  // bounds 9*(255-band) and 9*(255+band), times nine as shift and add
  assign band_lo  = WHITE_LEVEL - white_band;
  assign band_hi  = {1'b0, WHITE_LEVEL} + {1'b0, white_band};
  assign bound_lo = (BOUND_W'(band_lo) << 3) + BOUND_W'(band_lo);
  assign bound_hi = (BOUND_W'(band_hi) << 3) + BOUND_W'(band_hi);

  always_comb begin
    white = 1'b1;
    for (int k = 0; k < NUM_CHAN; k++) begin
      if (!((BOUND_W'(win_sum[k]) > bound_lo) && (BOUND_W'(win_sum[k]) < bound_hi))) begin
        white = 1'b0;
      end
    end
  end

  // border centers (top row or left column) and invalid positions give zero
  always_comb begin
    if (!s1_pos_valid || !s1_interior) begin
      mask = MASK_BORDER;
    end else if (white) begin
      mask = MASK_WHITE;
    end else begin
      mask = MASK_OTHER;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      m_tdata    <= mask;
      m_tuser[0] <= s1_pos_valid;
    end
  end

endmodule

@@ rtl/core/bmwm_ram.sv @@
// ----------------------------------------------------------------------------
// bmwm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bmwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/bmwm_checker.sv @@
// ----------------------------------------------------------------------------
// bmwm_checker
// port-level checks for the box mean white mask core
// ----------------------------------------------------------------------------
module bmwm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [bmwm_pkg::MASK_W-1:0] m_tdata,
  input logic [0:0]                  m_tuser
);

  import bmwm_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // only the three mask levels ever leave the block
  a_mask_level: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata == MASK_WHITE) || (m_tdata == MASK_OTHER)
                 || (m_tdata == MASK_BORDER))
    else $error("mask value is not a mask level");

  // positions not flagged as mask_valid carry a border mask
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == MASK_BORDER)
    else $error("mask set on an invalid position");

  // input is closed right after reset, as the line store clearing starts
  a_clear_closed: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input open right after reset");

endmodule

bind box_mean_white_mask_core bmwm_checker u_bmwm_checker (.*);
